// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PKIF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PKIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pkif_pkg.sv =====
package pkif_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int STATE_W          = 48;
  localparam int SUM_W            = 64;
  localparam int CNT_W            = 32;
  localparam int COEF_W           = 32;
  localparam int GAIN_W           = 31;
  localparam int START_W          = 32;
  localparam int FRAC_W           = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 32;
  localparam int MUL_W            = 32;
  localparam int PROD_W           = 2 * MUL_W;
  localparam int PHI_W            = STATE_W;
  localparam int TERM_W           = 54;
  localparam int CAP_W            = 53;
  localparam int WIDE_W           = 56;
  localparam int PRED_W           = WIDE_W - FRAC_W;
  localparam int DIFF_W           = 50;
  localparam int STEP_W           = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RHO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_M = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_R = 2'd3;

  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

  typedef enum logic [2:0] {
    A_ZERO    = 3'd0,
    A_MEAN_LO = 3'd1,
    A_MEAN_HI = 3'd2,
    A_MAG_LO  = 3'd3,
    A_MAG_HI  = 3'd4
  } asel_t;

  typedef enum logic [2:0] {
    B_ZERO   = 3'd0,
    B_RHO    = 3'd1,
    B_MAG_LO = 3'd2,
    B_GAIN   = 3'd3,
    B_KRW    = 3'd4
  } bsel_t;

  typedef enum logic [1:0] {
    D_NONE = 2'd0,
    D_LO   = 2'd1,
    D_HI   = 2'd2
  } dst_t;

  typedef enum logic [3:0] {
    ALU_NOP    = 4'd0,
    ALU_RHOM   = 4'd1,
    ALU_PRED   = 4'd2,
    ALU_INNOV  = 4'd3,
    ALU_ACCUM  = 4'd4,
    ALU_TERM_G = 4'd5,
    ALU_MEAN   = 4'd6,
    ALU_TERM_K = 4'd7,
    ALU_WALK   = 4'd8
  } alu_t;

  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,
    JMP_WAIT_IN = 2'd1,
    JMP_DONE    = 2'd2
  } jmp_t;

  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    dst_t  dst;
    alu_t  alu;
    jmp_t  jmp;
  } uword_t;

  typedef struct packed {
    logic                      hit;
    logic signed [STATE_W-1:0] value;
  } clamp_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{A_ZERO, B_ZERO, D_NONE, ALU_NOP, JMP_NEXT};
    case (step)
      4'd0: begin
        w.jmp = JMP_WAIT_IN;
      end
      4'd1: begin
        w.a_sel = A_MEAN_LO;
        w.b_sel = B_RHO;
        w.dst   = D_LO;
      end
      4'd2: begin
        w.a_sel = A_MEAN_HI;
        w.b_sel = B_RHO;
        w.dst   = D_HI;
      end
      4'd3: begin
        w.alu = ALU_RHOM;
      end
      4'd4: begin
        w.alu = ALU_PRED;
      end
      4'd5: begin
        w.alu = ALU_INNOV;
      end
      4'd6: begin
        w.a_sel = A_MAG_LO;
        w.b_sel = B_MAG_LO;
        w.dst   = D_LO;
      end
      4'd7: begin
        w.a_sel = A_MAG_LO;
        w.b_sel = B_GAIN;
        w.dst   = D_LO;
        w.alu   = ALU_ACCUM;
      end
      4'd8: begin
        w.a_sel = A_MAG_HI;
        w.b_sel = B_GAIN;
        w.dst   = D_HI;
      end
      4'd9: begin
        w.a_sel = A_MAG_LO;
        w.b_sel = B_KRW;
        w.dst   = D_LO;
        w.alu   = ALU_TERM_G;
      end
      4'd10: begin
        w.a_sel = A_MAG_HI;
        w.b_sel = B_KRW;
        w.dst   = D_HI;
        w.alu   = ALU_MEAN;
      end
      4'd11: begin
        w.alu = ALU_TERM_K;
      end
      4'd12: begin
        w.alu = ALU_WALK;
        w.jmp = JMP_DONE;
      end
      default: begin
        w.jmp = JMP_DONE;
      end
    endcase
    return w;
  endfunction

  function automatic clamp_t clamp_state(input logic signed [TERM_W:0] x);
    logic signed [TERM_W:0] hi_lim;
    logic signed [TERM_W:0] lo_lim;
    clamp_t r;
    hi_lim = (55'sd1 <<< (STATE_W - 1)) - 55'sd1;
    lo_lim = -(55'sd1 <<< (STATE_W - 1));
    r.hit  = 1'b0;
    r.value = x[STATE_W-1:0];
    if (x > hi_lim) begin
      r.hit   = 1'b1;
      r.value = hi_lim[STATE_W-1:0];
    end else if (x < lo_lim) begin
      r.hit   = 1'b1;
      r.value = lo_lim[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/par_kalman_innovation_filter.sv =====
// Channel  Direction  Handshake            Payload
// in       slave      in_tvalid/in_tready  in_tdata: sample; in_tlast: last
// out      master     out_tvalid/out_tready out_tdata: innovation, sum_squares,
//                                          sample_count; out_tlast; out_tuser
// cfg      write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A result is posted at the end of the step program, which runs seven passes through one
// shared 32x32 multiplier plus the rounding and update steps; no new sample is taken
// before the program is through with the last one.
// The next sample is accepted once the program is back at its first step.
// The final step waits while the output register still holds an untaken result.
// Synchronous active-low reset zeroes the control, config and series registers, not the datapath ones.
// Configuration writes are always taken, with cfg_ready tied high.
module par_kalman_innovation_filter #(
  parameter int SAMPLE_WIDTH = pkif_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: innovation, sum_squares, sample_count.
  output logic [((SAMPLE_WIDTH+pkif_pkg::SUM_W+pkif_pkg::CNT_W+7)/8)*8-1:0] out_tdata,
  output logic                                   out_tlast,
  // Fields from bit 0: overflow.
  output logic                                   out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pkif_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pkif_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pkif_pkg::*;
`include "assert_macros.svh"

  localparam int OUT_W = ((SAMPLE_WIDTH + SUM_W + CNT_W + 7) / 8) * 8;
  localparam logic signed [DIFF_W-1:0] INNOV_MAX =
    DIFF_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DIFF_W-1:0] INNOV_MIN =
    DIFF_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
  localparam logic [WIDE_W-1:0] CAP_WIDE = WIDE_W'(64'd1 << (CAP_W - 1));
  localparam logic [PHI_W-1:0] HI_LIM14 = PHI_W'(64'd1 << 34);

  logic [STEP_W-1:0]               step_r, step_nxt;
  logic signed [COEF_W-1:0]        rho_r, rho_nxt;
  logic [GAIN_W-1:0]               gain_r, gain_nxt;
  logic signed [START_W-1:0]       startm_r, startm_nxt;
  logic signed [START_W-1:0]       startr_r, startr_nxt;
  logic signed [STATE_W-1:0]       mean_r, mean_nxt;
  logic signed [STATE_W-1:0]       walk_r, walk_nxt;
  logic [SUM_W-1:0]                ssum_r, ssum_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            sat_r, sat_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic signed [SAMPLE_WIDTH-1:0]  sample_r, sample_nxt;
  logic                            last_r, last_nxt;
  logic [PROD_W-1:0]               plo_r, plo_nxt;
  logic [PHI_W-1:0]                phi_r, phi_nxt;
  logic signed [TERM_W-1:0]        rhom_r, rhom_nxt;
  logic signed [TERM_W-1:0]        term_r, term_nxt;
  logic signed [PRED_W-1:0]        pred_r, pred_nxt;
  logic signed [SAMPLE_WIDTH-1:0]  innov_r, innov_nxt;
  logic [STATE_W-1:0]              mag_r, mag_nxt;
  logic                            ineg_r, ineg_nxt;
  logic [SAMPLE_WIDTH-1:0]         out_innov_r, out_innov_nxt;
  logic [SUM_W-1:0]                out_sum_r, out_sum_nxt;
  logic [CNT_W-1:0]                out_cnt_r, out_cnt_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_ovf_r, out_ovf_nxt;

  uword_t                          uw;
  logic                            out_free;
  logic                            out_wr;
  logic [STATE_W-1:0]              mean_mag;
  logic [MUL_W-1:0]                rho_mag;
  logic signed [COEF_W:0]          krw;
  logic [MUL_W-1:0]                krw_mag;
  logic [MUL_W-1:0]                mul_a;
  logic [MUL_W-1:0]                mul_b;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W:0]                 rnd30;
  logic [PROD_W:0]                 rnd14;
  logic [WIDE_W-1:0]               csum;
  logic                            chi_big;
  logic                            cneg;
  logic [CAP_W-1:0]                cmag;
  logic signed [TERM_W-1:0]        cterm;
  logic signed [WIDE_W-1:0]        psum;
  logic signed [DIFF_W-1:0]        diff;
  logic signed [SAMPLE_WIDTH-1:0]  innov_c;
  logic                            innov_hit;
  logic signed [STATE_W-1:0]       innov_ext;
  logic [SUM_W-1:0]                sq;
  logic [SUM_W:0]                  acc;
  clamp_t                          mc;
  clamp_t                          wc;

  assign uw        = ucode(step_r);
  assign in_tready = (uw.jmp == JMP_WAIT_IN);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign out_wr    = (uw.jmp == JMP_DONE) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_sum_r, out_innov_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // Sign-magnitude operands of the shared multiplier.
  assign mean_mag = mean_r[STATE_W-1] ? unsigned'(-mean_r) : unsigned'(mean_r);
  assign rho_mag  = rho_r[COEF_W-1] ? unsigned'(-rho_r) : unsigned'(rho_r);
  assign krw      = (33'sd1 <<< 30) - signed'({2'b00, gain_r});
  assign krw_mag  = krw[COEF_W] ? MUL_W'(unsigned'(-krw)) : MUL_W'(unsigned'(krw));

  always_comb begin
    case (uw.a_sel)
      A_MEAN_LO: mul_a = mean_mag[MUL_W-1:0];
      A_MEAN_HI: mul_a = MUL_W'(mean_mag[STATE_W-1:MUL_W]);
      A_MAG_LO:  mul_a = mag_r[MUL_W-1:0];
      A_MAG_HI:  mul_a = MUL_W'(mag_r[STATE_W-1:MUL_W]);
      default:   mul_a = '0;
    endcase
    case (uw.b_sel)
      B_RHO:    mul_b = rho_mag;
      B_MAG_LO: mul_b = mag_r[MUL_W-1:0];
      B_GAIN:   mul_b = MUL_W'(gain_r);
      B_KRW:    mul_b = krw_mag;
      default:  mul_b = '0;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Rounded, capped product term built from the low and high partial products.
  always_comb begin
    rnd30 = {1'b0, plo_r} + (65'd1 << 29);
    rnd14 = {1'b0, plo_r} + (65'd1 << 13);
    if (uw.alu == ALU_RHOM) begin
      chi_big = 1'b0;
      csum    = {6'b0, phi_r, 2'b0} + WIDE_W'(rnd30[PROD_W:30]);
    end else begin
      chi_big = phi_r > HI_LIM14;
      csum    = {3'b0, phi_r[34:0], 18'b0} + WIDE_W'(rnd14[PROD_W:14]);
    end
    case (uw.alu)
      ALU_RHOM:   cneg = mean_r[STATE_W-1] ^ rho_r[COEF_W-1];
      ALU_TERM_K: cneg = ineg_r ^ krw[COEF_W];
      default:    cneg = ineg_r;
    endcase
    if (chi_big || csum > CAP_WIDE) begin
      cmag = CAP_WIDE[CAP_W-1:0];
    end else begin
      cmag = csum[CAP_W-1:0];
    end
    cterm = cneg ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});
  end

  always_comb begin
    psum = WIDE_W'(rhom_r) + WIDE_W'(walk_r) + 56'sd32768;
    diff = DIFF_W'(sample_r) - DIFF_W'(pred_r);
    innov_hit = 1'b1;
    if (diff > INNOV_MAX) begin
      innov_c = INNOV_MAX[SAMPLE_WIDTH-1:0];
    end else if (diff < INNOV_MIN) begin
      innov_c = INNOV_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      innov_c   = diff[SAMPLE_WIDTH-1:0];
      innov_hit = 1'b0;
    end
    innov_ext = STATE_W'(innov_c);
    sq  = (mag_r[STATE_W-1:MUL_W] != '0) ? '1 : plo_r;
    acc = {1'b0, ssum_r} + {1'b0, sq};
    mc  = clamp_state((TERM_W + 1)'(rhom_r) + (TERM_W + 1)'(term_r));
    wc  = clamp_state((TERM_W + 1)'(walk_r) + (TERM_W + 1)'(term_r));
  end

  always_comb begin
    step_nxt      = step_r;
    rho_nxt       = rho_r;
    gain_nxt      = gain_r;
    startm_nxt    = startm_r;
    startr_nxt    = startr_r;
    mean_nxt      = mean_r;
    walk_nxt      = walk_r;
    ssum_nxt      = ssum_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    rhom_nxt      = rhom_r;
    term_nxt      = term_r;
    pred_nxt      = pred_r;
    innov_nxt     = innov_r;
    mag_nxt       = mag_r;
    ineg_nxt      = ineg_r;
    out_innov_nxt = out_innov_r;
    out_sum_nxt   = out_sum_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    case (uw.jmp)
      JMP_WAIT_IN: begin
        if (in_tvalid) begin
          step_nxt   = step_r + 4'd1;
          sample_nxt = in_tdata[SAMPLE_WIDTH-1:0];
          last_nxt   = in_tlast;
        end
      end
      JMP_DONE: begin
        if (out_free) begin
          step_nxt = STEP_IDLE;
        end
      end
      default: begin
        step_nxt = step_r + 4'd1;
      end
    endcase

    case (uw.dst)
      D_LO:    plo_nxt = prod;
      D_HI:    phi_nxt = prod[PHI_W-1:0];
      default: ;
    endcase

    case (uw.alu)
      ALU_RHOM: begin
        rhom_nxt = cterm;
      end
      ALU_PRED: begin
        pred_nxt = psum[WIDE_W-1:FRAC_W];
      end
      ALU_INNOV: begin
        innov_nxt = innov_c;
        ineg_nxt  = innov_c[SAMPLE_WIDTH-1];
        mag_nxt   = innov_c[SAMPLE_WIDTH-1] ? unsigned'(-innov_ext) : unsigned'(innov_ext);
        sat_nxt   = sat_r | innov_hit;
      end
      ALU_ACCUM: begin
        if (mag_r[STATE_W-1:MUL_W] != '0) begin
          sat_nxt = 1'b1;
        end
        if (acc[SUM_W]) begin
          ssum_nxt = '1;
          sat_nxt  = 1'b1;
        end else begin
          ssum_nxt = acc[SUM_W-1:0];
        end
        if (&cnt_r) begin
          sat_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ALU_TERM_G, ALU_TERM_K: begin
        term_nxt = cterm;
      end
      ALU_MEAN: begin
        mean_nxt = mc.value;
        sat_nxt  = sat_r | mc.hit;
      end
      ALU_WALK: begin
        if (out_wr) begin
          walk_nxt      = wc.value;
          sat_nxt       = sat_r | wc.hit;
          out_valid_nxt = 1'b1;
          out_innov_nxt = innov_r;
          out_sum_nxt   = ssum_r;
          out_cnt_nxt   = cnt_r;
          out_last_nxt  = last_r;
          out_ovf_nxt   = sat_r | wc.hit;
          if (last_r) begin
            mean_nxt = {startm_r, 16'b0};
            walk_nxt = {startr_r, 16'b0};
            ssum_nxt = '0;
            cnt_nxt  = '0;
            sat_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_RHO: begin
          rho_nxt = cfg_data;
        end
        REG_GAIN: begin
          gain_nxt = cfg_data[GAIN_W-1:0];
        end
        REG_START_M: begin
          startm_nxt = cfg_data;
          if (cnt_r == '0) begin
            mean_nxt = {cfg_data, 16'b0};
          end
        end
        REG_START_R: begin
          startr_nxt = cfg_data;
          if (cnt_r == '0) begin
            walk_nxt = {cfg_data, 16'b0};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      rho_r       <= '0;
      gain_r      <= '0;
      startm_r    <= '0;
      startr_r    <= '0;
      mean_r      <= '0;
      walk_r      <= '0;
      ssum_r      <= '0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      rho_r       <= rho_nxt;
      gain_r      <= gain_nxt;
      startm_r    <= startm_nxt;
      startr_r    <= startr_nxt;
      mean_r      <= mean_nxt;
      walk_r      <= walk_nxt;
      ssum_r      <= ssum_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    rhom_r      <= rhom_nxt;
    term_r      <= term_nxt;
    pred_r      <= pred_nxt;
    innov_r     <= innov_nxt;
    mag_r       <= mag_nxt;
    ineg_r      <= ineg_nxt;
    out_innov_r <= out_innov_nxt;
    out_sum_r   <= out_sum_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  `PKIF_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "sample taken while busy")
  `PKIF_ASSERT_NEXT(a_result_ends_program, out_wr, out_valid_r && step_r == STEP_IDLE, "result not posted")
  `PKIF_ASSERT_NEXT(a_reload_after_last, out_wr && last_r, cnt_r == '0 && ssum_r == '0 && !sat_r, "no reload")
  `PKIF_ASSERT_SAME(a_step_in_program, 1'b1, step_r <= STEP_LAST, "step counter left the program")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pkif_pkg::*;

  localparam int IN_W = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_WIDTH_DEF + SUM_W + CNT_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_CAP = 100;

  typedef struct {
    logic [31:0] innovation;
    logic [63:0] sum_squares;
    logic [31:0] sample_count;
    logic        end_of_series;
    logic        overflow;
  } kf_out_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kf_out_t filter_outputs_q[$];
  int      mismatch_count;
  int      cycle_count;
  int      hold_left;
  bit      idle_on;
  bit      stall_on;

  // Mirror of the filter registers and per-series state.
  longint          rho_q30;
  longint          gain_q30;
  longint          start_mean;
  longint          start_walk;
  longint          mean_est;
  longint          walk_est;
  longint unsigned sq_sum;
  longint unsigned n_taken;
  bit              sat_seen;

  par_kalman_innovation_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("par_kalman_innovation_filter: mismatch");
      $finish;
    end
  end

  // Rounded product a*b/2^sh, ties away from zero, magnitude capped at 2^52.
  function automatic longint round_product(input longint a, input longint b, input int sh);
    bit              neg;
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned mag;
    longint unsigned cap;
    cap = 64'd1 << 52;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    hi = (ua >> 32) * ub;
    lo = (ua & 64'hFFFF_FFFF) * ub;
    lo = (lo + (64'd1 << (sh - 1))) >> sh;
    if (hi > (cap >> (32 - sh)))
      mag = cap;
    else
      mag = (hi << (32 - sh)) + lo;
    if (mag > cap)
      mag = cap;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_bits(input longint x, input int w);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) << (w - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (x > hi_lim) begin
      sat_seen = 1'b1;
      return hi_lim;
    end
    if (x < lo_lim) begin
      sat_seen = 1'b1;
      return lo_lim;
    end
    return x;
  endfunction

  function automatic void start_series();
    mean_est = start_mean * 65536;
    walk_est = start_walk * 65536;
    sq_sum   = 0;
    n_taken  = 0;
    sat_seen = 1'b0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_RHO: begin
        rho_q30 = longint'($signed(d));
      end
      REG_GAIN: begin
        gain_q30 = longint'(d[30:0]);
      end
      REG_START_M: begin
        start_mean = longint'($signed(d));
        if (n_taken == 0)
          mean_est = start_mean * 65536;
      end
      REG_START_R: begin
        start_walk = longint'($signed(d));
        if (n_taken == 0)
          walk_est = start_walk * 65536;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_innovation(input logic [31:0] obs, input bit last);
    longint          x;
    longint          rho_m;
    longint          xhat;
    longint          pred;
    longint          innov;
    longint          k_rw;
    longint unsigned mag;
    longint unsigned sq;
    kf_out_t         r;
    x     = longint'($signed(obs));
    rho_m = round_product(mean_est, rho_q30, 30);
    xhat  = rho_m + walk_est;
    pred  = (xhat + 32768) >>> 16;
    innov = clamp_bits(x - pred, SAMPLE_WIDTH_DEF);
    mag   = (innov < 0) ? -innov : innov;
    k_rw  = (longint'(1) << 30) - gain_q30;
    if ((mag >> 32) != 0) begin
      sq = ~64'd0;
      sat_seen = 1'b1;
    end else begin
      sq = mag * mag;
    end
    if (sq_sum > ~64'd0 - sq) begin
      sq_sum = ~64'd0;
      sat_seen = 1'b1;
    end else begin
      sq_sum = sq_sum + sq;
    end
    if (n_taken >= 64'hFFFF_FFFF)
      sat_seen = 1'b1;
    else
      n_taken = n_taken + 1;
    mean_est = clamp_bits(rho_m + round_product(innov, gain_q30, 14), STATE_W);
    walk_est = clamp_bits(walk_est + round_product(innov, k_rw, 14), STATE_W);
    r.innovation    = innov[31:0];
    r.sum_squares   = sq_sum;
    r.sample_count  = n_taken[31:0];
    r.end_of_series = last;
    r.overflow      = sat_seen;
    filter_outputs_q.push_back(r);
    if (last)
      start_series();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    kf_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (filter_outputs_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[63:0], 64'd0);
      end else begin
        e = filter_outputs_q.pop_front();
        if (out_tdata[31:0] !== e.innovation)
          report_mismatch("innovation", 64'(out_tdata[31:0]), 64'(e.innovation));
        if (out_tdata[95:32] !== e.sum_squares)
          report_mismatch("sum_squares", out_tdata[95:32], e.sum_squares);
        if (out_tdata[127:96] !== e.sample_count)
          report_mismatch("sample_count", 64'(out_tdata[127:96]), 64'(e.sample_count));
        if (out_tlast !== e.end_of_series)
          report_mismatch("end_of_series", 64'(out_tlast), 64'(e.end_of_series));
        if (out_tuser !== e.overflow)
          report_mismatch("overflow", 64'(out_tuser), 64'(e.overflow));
      end
    end
  end

  function automatic int draw_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60)
      return 0;
    if (p < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The receiver also honors a long hold-off requested by a test.
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = draw_gap();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [31:0] obs, input bit last);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= obs;
    in_tlast  <= last;
    do
      @(posedge clk);
    while (!in_tready);
    predict_innovation(obs, last);
    gap = idle_on ? draw_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do
      @(posedge clk);
    while (!cfg_ready);
    apply_register(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (filter_outputs_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    settle();
  endtask

  task automatic test_register_extremes();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    write_register(REG_RHO, 32'h7FFF_FFFF);
    write_register(REG_GAIN, 32'hFFFF_FFFF);
    write_register(REG_START_M, 32'h7FFF_FFFF);
    write_register(REG_START_R, 32'h7FFF_FFFF);
    repeat (5) send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    settle();
    write_register(REG_RHO, 32'h8000_0000);
    write_register(REG_GAIN, 32'h0000_0000);
    write_register(REG_START_M, 32'h8000_0000);
    write_register(REG_START_R, 32'h8000_0000);
    repeat (3) send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    settle();
    write_register(REG_RHO, 32'h4000_0000);
    write_register(REG_GAIN, 32'h4000_0000);
    write_register(REG_RHO, 32'hC000_0000);
    send_sample(32'h0000_8000, 1'b1);
    settle();
  endtask

  // Start values load at once only while no sample of the series is in.
  task automatic test_start_reload();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    write_register(REG_RHO, 32'h3000_0000);
    write_register(REG_GAIN, 32'h1000_0000);
    write_register(REG_START_M, 32'h0005_0000);
    write_register(REG_START_R, 32'hFFFD_0000);
    send_sample(32'h0004_0000, 1'b0);
    send_sample(32'h0002_8000, 1'b0);
    send_sample(32'hFFFF_0000, 1'b0);
    settle();
    write_register(REG_START_M, 32'h0010_0000);
    write_register(REG_START_R, 32'h0020_0000);
    send_sample(32'h0001_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'h0030_0000, 1'b1);
    settle();
  endtask

  task automatic test_backpressure();
    idle_on   = 1'b0;
    stall_on  = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 10; i++)
      send_sample($urandom_range(0, 32'h0004_0000), 1'b0);
    settle();
    for (int i = 0; i < 5; i++)
      send_sample($urandom_range(0, 32'h0004_0000), i == 4);
    settle();
  endtask

  function automatic logic [31:0] pick_coef(input bit is_gain);
    int p;
    p = $urandom_range(0, 9);
    if (p < 7)
      return is_gain ? $urandom_range(0, 32'h4000_0000)
                     : $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    if (p < 8)
      return is_gain ? ($urandom_range(0, 1) ? 32'h4000_0000 : 32'h0)
                     : ($urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_start();
    int p;
    p = $urandom_range(0, 9);
    if (p < 6)
      return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (p < 8)
      return $urandom();
    case ($urandom_range(0, 2))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return 32'h0;
    endcase
  endfunction

  task automatic next_sample(inout logic [31:0] trail, output logic [31:0] obs);
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) begin
      trail = trail + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      obs = trail;
    end else if (p < 85) begin
      obs = $urandom();
    end else if (p < 95) begin
      case ($urandom_range(0, 4))
        0: obs = 32'h7FFF_FFFF;
        1: obs = 32'h8000_0000;
        2: obs = 32'hFFFF_FFFF;
        3: obs = 32'h0000_0001;
        default: obs = 32'h0;
      endcase
    end else begin
      obs = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    end
  endtask

  task automatic test_random_series();
    int                   sent;
    int                   len;
    bit                   open;
    bit                   last;
    logic [31:0]          trail;
    logic [31:0]          obs;
    logic [CFG_IDX_W-1:0] idx;
    sent  = 0;
    trail = 32'h0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      idle_on  = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      idx = CFG_IDX_W'($urandom_range(0, 3));
      repeat (4) begin
        if ($urandom_range(0, 2) != 0) begin
          if (idx == REG_RHO)
            write_register(idx, pick_coef(1'b0));
          else if (idx == REG_GAIN)
            write_register(idx, pick_coef(1'b1));
          else
            write_register(idx, pick_start());
        end
        idx = idx + 1'b1;
      end
      repeat ($urandom_range(1, 4)) begin
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
        open = $urandom_range(0, 6) == 0;
        for (int i = 0; i < len; i++) begin
          next_sample(trail, obs);
          last = (i == len - 1) ? !open : ($urandom_range(0, 39) == 0);
          send_sample(obs, last);
        end
        sent += len;
      end
    end
    settle();
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    hold_left      = 0;
    idle_on        = 1'b0;
    stall_on       = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    rho_q30        = 0;
    gain_q30       = 0;
    start_mean     = 0;
    start_walk     = 0;
    start_series();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_extremes();
    test_start_reload();
    test_backpressure();
    test_random_series();

    if (mismatch_count == 0)
      $display("par_kalman_innovation_filter: match");
    else
      $display("par_kalman_innovation_filter: mismatch");
    $finish;
  end

endmodule
